@@ rtl/core/rtt_pkg.sv @@
// Shared types and codes for the request timeout table.
`timescale 1ns / 1ps

package rtt_pkg;

	// Command codes carried by an item.
	typedef enum logic [1:0] {
		CMD_SET     = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_PROCESS = 2'd2
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ADDED        = 3'd0,
		ST_UPDATED      = 3'd1,
		ST_FULL         = 3'd2,
		ST_REMOVED      = 3'd3,
		ST_NOT_FOUND    = 3'd4,
		ST_EXPIRED      = 3'd5,
		ST_NONE_EXPIRED = 3'd6
	} status_t;

	// One table slot as stored in memory.
	typedef struct packed {
		logic        valid;
		logic [31:0] id;
		logic [31:0] deadline;
	} entry_t;

	// Flags from the slot compare unit.
	typedef struct packed {
		logic match;
		logic expired;
		logic free;
	} cmp_t;

endpackage

@@ rtl/core/rtt_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module rtt_mem
	import rtt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write one slot per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read data.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rtt_cmp.sv @@
// Slot compare unit: id match, expiry test and free test for one slot.
`timescale 1ns / 1ps

module rtt_cmp
	import rtt_pkg::*;
(
	input  entry_t      slot,
	input  logic [31:0] key,
	input  logic [31:0] now_time,
	output cmp_t        flags
);

	// Compare the slot against the item's id and the current time.
	always_comb begin
		flags.match   = slot.valid && (slot.id == key);
		flags.expired = slot.valid && (now_time >= slot.deadline);
		flags.free    = !slot.valid;
	end

endmodule

@@ rtl/core/request_timeout_table.sv @@
// Timing: an item holds busy through the scan, drain and finish states; its final result strobes as busy drops.
// Throughput: a new item is taken only once the last is finished; the memory scan reads one slot per cycle.
// Process results come in slot order, each held until the next expiry or the end of the scan, final one marked by last.
// Reset: arst_n clears control; a clearing pass over every slot then empties the table.
// An item with the unused command code is not taken and gives no result.
// Results cannot be held off, so nothing in the block ever stalls on the output side.
`timescale 1ns / 1ps

module request_timeout_table
	import rtt_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] request_id,
	input  logic [31:0] deadline,
	input  logic [31:0] now,
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [31:0] expired_id,
	output logic        last
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] addr_q;
	cmd_t          cmd_q;
	logic [31:0]   id_q;
	logic [31:0]   dl_q;
	logic [31:0]   now_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          hit_q;
	logic [AW-1:0] hit_addr_q;
	logic          free_q;
	logic [AW-1:0] free_addr_q;
	logic          pend_q;
	logic [31:0]   pend_id_q;
	logic          result_valid_q;
	status_t       status_q;
	logic [31:0]   expired_id_q;
	logic          last_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	entry_t        rd_data;
	cmp_t          flags;
	logic          cmd_ok;
	logic          eval;
	logic          mid_emit;

	rtt_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	rtt_cmp u_cmp (
		.slot    (rd_data),
		.key     (id_q),
		.now_time(now_q),
		.flags   (flags)
	);

	assign cmd_ok = (cmd == CMD_SET) || (cmd == CMD_REMOVE) || (cmd == CMD_PROCESS);
	assign eval   = rd_vld_s1 && ((state_q == S_SCAN) || (state_q == S_DRAIN));

	// Release a held expiry when another one follows it during the scan.
	assign mid_emit = eval && (cmd_q == CMD_PROCESS) && flags.expired && pend_q;

	// Drive the memory write port: clear sweep, expiry frees, final update.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
			end
			S_SCAN, S_DRAIN: begin
				if (eval && (cmd_q == CMD_PROCESS) && flags.expired) begin
					mem_we = 1'b1;
				end
			end
			S_FINISH: begin
				if (cmd_q == CMD_SET) begin
					mem_wdata = '{valid: 1'b1, id: id_q, deadline: dl_q};
					if (hit_q) begin
						mem_we    = 1'b1;
						mem_waddr = hit_addr_q;
					end else if (free_q) begin
						mem_we    = 1'b1;
						mem_waddr = free_addr_q;
					end
				end else if ((cmd_q == CMD_REMOVE) && hit_q) begin
					mem_we    = 1'b1;
					mem_waddr = hit_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer: hold state, scan slots, emit results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			addr_q         <= '0;
			cmd_q          <= CMD_SET;
			id_q           <= '0;
			dl_q           <= '0;
			now_q          <= '0;
			rd_vld_s1      <= 1'b0;
			rd_addr_s1     <= '0;
			hit_q          <= 1'b0;
			hit_addr_q     <= '0;
			free_q         <= 1'b0;
			free_addr_q    <= '0;
			pend_q         <= 1'b0;
			pend_id_q      <= '0;
			result_valid_q <= 1'b0;
			status_q       <= ST_ADDED;
			expired_id_q   <= '0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= (state_q == S_FINISH) || mid_emit;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (start && cmd_ok) begin
						cmd_q   <= cmd_t'(cmd);
						id_q    <= request_id;
						dl_q    <= deadline;
						now_q   <= now;
						addr_q  <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1  <= 1'b1;
					rd_addr_s1 <= addr_q;
					if (addr_q == LAST_ADDR) begin
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= S_FINISH;
				end
				S_FINISH: begin
					last_q       <= 1'b1;
					expired_id_q <= ((cmd_q == CMD_PROCESS) && pend_q) ? pend_id_q : id_q;
					pend_q       <= 1'b0;
					state_q      <= S_IDLE;
					unique case (cmd_q)
						CMD_SET: begin
							if (hit_q) begin
								status_q <= ST_UPDATED;
							end else if (free_q) begin
								status_q <= ST_ADDED;
							end else begin
								status_q <= ST_FULL;
							end
						end
						CMD_REMOVE: begin
							status_q <= hit_q ? ST_REMOVED : ST_NOT_FOUND;
						end
						CMD_PROCESS: begin
							status_q <= pend_q ? ST_EXPIRED : ST_NONE_EXPIRED;
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Evaluate the slot read in the previous cycle.
			if (eval) begin
				unique case (cmd_q)
					CMD_SET: begin
						if (flags.match && !hit_q) begin
							hit_q      <= 1'b1;
							hit_addr_q <= rd_addr_s1;
						end
						if (flags.free && !free_q) begin
							free_q      <= 1'b1;
							free_addr_q <= rd_addr_s1;
						end
					end
					CMD_REMOVE: begin
						if (flags.match && !hit_q) begin
							hit_q      <= 1'b1;
							hit_addr_q <= rd_addr_s1;
						end
					end
					CMD_PROCESS: begin
						// Release the held expiry now that another follows it.
						if (flags.expired) begin
							if (pend_q) begin
								status_q     <= ST_EXPIRED;
								expired_id_q <= pend_id_q;
								last_q       <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_id_q <= rd_data.id;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign expired_id   = expired_id_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result while block still busy");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!rd_vld_s1 && !pend_q))
		else $error("scan state left over in idle");

	a_expired_from_process: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status_q == ST_EXPIRED)) |-> (cmd_q == CMD_PROCESS))
		else $error("expiry reported for a non-process item");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd_ok) |=> (busy && (addr_q == '0) && !result_valid))
		else $error("accepted item did not start a scan at slot zero");
`endif

endmodule
